/* src/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the streaming substring replace block.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int QUEUE_DEPTH     = 8;

   localparam logic [1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       text_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
   } rsp_type;

   typedef struct packed {
      logic en;
      logic shift;
      logic take_new;
   } cell_ctl_type;

endpackage

/* src/ssr_cell.sv */
// ----------------------------------------------------------------------------
// ssr_cell
// One window byte: holds it, compares it with its pattern lane, hands it on.
// ----------------------------------------------------------------------------
module ssr_cell (
   input  logic                 clock,
   input  ssr_pkg::cell_ctl_type ctl,
   input  logic [7:0]           text_byte,
   input  logic [7:0]           nbr_byte,
   input  logic [7:0]           pat_byte,
   output logic [7:0]           pushed_byte,
   output logic                 eq
);
   import ssr_pkg::*;

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign pushed_byte = ctl.take_new ? text_byte : byte_ff;
   assign eq          = (pushed_byte == pat_byte);
   assign byte_in     = ctl.shift ? nbr_byte : pushed_byte;

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         byte_ff <= byte_in;
      end
   end

endmodule

/* src/ssr_outq.sv */
// ----------------------------------------------------------------------------
// ssr_outq
// Result queue: loaded in parallel, drained from the head one transfer per cycle while take is high.
// ----------------------------------------------------------------------------
module ssr_outq (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic [3:0]       load_cnt,
   input  ssr_pkg::rsp_type load_ent [ssr_pkg::QUEUE_DEPTH],
   input  logic             take,
   output ssr_pkg::rsp_type head,
   output logic [3:0]       cnt
);
   import ssr_pkg::*;

   rsp_type    ent_ff [QUEUE_DEPTH];
   logic [3:0] cnt_ff;
   logic [3:0] cnt_in;

   assign head = ent_ff[0];
   assign cnt  = cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = load_cnt;
      end else if (take) begin
         cnt_in = cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if (load) begin
            ent_ff[k] <= load_ent[k];
         end else if (take && k < QUEUE_DEPTH - 1) begin
            ent_ff[k] <= ent_ff[k + 1];
         end
      end
   end

endmodule

/* src/stream_substring_replace_top.sv */
// ----------------------------------------------------------------------------
// stream_substring_replace_top
// Find and replace all over a byte stream, pattern window as a row of cells.
//
//   port    dir  payload            transfer
//   req_    in   req_type           req_valid & !req_stall
//   rsp_    out  rsp_type           rsp_valid & !rsp_stall
//   csr_    in   64-bit wdata       csr_we, index 0..3
//
// one byte per cycle while each byte yields at most one result and rsp_stall
// is low; a byte with more results stalls the input; the result queue drains
// one entry per cycle unless stalled, taking the next byte with its last entry
// results appear in the output register the cycle after the input transfer
// synchronous reset clears counts; window bytes are unknown until written
// ----------------------------------------------------------------------------
module stream_substring_replace_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   import ssr_pkg::*;

   localparam logic [3:0] MAX_PAT_LEN = 4'(MAX_PATTERN);
   localparam logic [3:0] MAX_REP_LEN = 4'(MAX_REPLACEMENT);

   logic [63:0] pattern_bytes_ff;
   logic [3:0]  pattern_length_ff;
   logic [63:0] replacement_bytes_ff;
   logic [3:0]  replacement_length_ff;
   logic [2:0]  pend_ff;
   logic [2:0]  pend_in;

   logic [3:0]  plen;
   logic [3:0]  rlen;
   logic [3:0]  pend_ext;
   logic        decide;
   logic        hit;
   logic        req_take;
   logic        rsp_take;
   logic        last;
   logic        use_repl;
   logic        bare;
   logic        shift;
   logic [3:0]  n;
   logic [3:0]  q_cnt;
   logic        q_load;

   cell_ctl_type ctl [MAX_PATTERN];
   logic [7:0]   pushed [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] eq;
   logic [MAX_PATTERN-1:0] lane_used;
   rsp_type      ent [QUEUE_DEPTH];

   assign plen     = (pattern_length_ff > MAX_PAT_LEN) ? MAX_PAT_LEN : pattern_length_ff;
   assign rlen     = (replacement_length_ff > MAX_REP_LEN) ? MAX_REP_LEN
                                                            : replacement_length_ff;
   assign pend_ext = {1'b0, pend_ff};
   assign last     = req_data.text_last;
   assign rsp_take = rsp_valid & ~rsp_stall;
   assign req_take = req_valid & ~req_stall;
   assign decide   = (plen != 4'd0) && (pend_ext + 4'd1 == plen);
   assign hit      = &(eq | ~lane_used);

   // cell row
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      assign lane_used[j]   = (4'(j) < plen);
      assign ctl[j].en       = req_take && (plen != 4'd0);
      assign ctl[j].shift    = shift;
      assign ctl[j].take_new = (4'(j) >= pend_ext);

      ssr_cell u_cell (
         .clock       (clock),
         .ctl         (ctl[j]),
         .text_byte   (req_data.text_byte),
         .nbr_byte    ((j == MAX_PATTERN - 1) ? req_data.text_byte
                                              : pushed[(j + 1) % MAX_PATTERN]),
         .pat_byte    (pattern_bytes_ff[8*j +: 8]),
         .pushed_byte (pushed[j]),
         .eq          (eq[j])
      );
   end

   // decision
   always_comb begin
      use_repl = 1'b0;
      bare     = 1'b0;
      shift    = 1'b0;
      n        = 4'd0;
      pend_in  = pend_ff;
      if (plen == 4'd0) begin
         n       = 4'd1;
         pend_in = 3'd0;
      end else if (decide && hit) begin
         use_repl = 1'b1;
         pend_in  = 3'd0;
         if (rlen == 4'd0 && last) begin
            bare = 1'b1;
            n    = 4'd1;
         end else begin
            n = rlen;
         end
      end else if (decide) begin
         shift   = 1'b1;
         n       = last ? plen : 4'd1;
         pend_in = last ? 3'd0 : 3'(plen - 4'd1);
      end else begin
         n       = last ? pend_ext + 4'd1 : 4'd0;
         pend_in = last ? 3'd0 : 3'(pend_ext + 4'd1);
      end
   end

   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         ent[j].out_byte  = bare ? 8'd0
                          : (use_repl ? replacement_bytes_ff[8*j +: 8]
                                      : pushed[j % MAX_PATTERN]);
         ent[j].out_valid = ~bare;
         ent[j].out_last  = last && (4'(j) == n - 4'd1);
      end
   end

   assign q_load    = req_take && (n != 4'd0);
   assign req_stall = ~((q_cnt == 4'd0) || (q_cnt == 4'd1 && rsp_take));
   assign rsp_valid = (q_cnt != 4'd0);

   ssr_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .load     (q_load),
      .load_cnt (n),
      .load_ent (ent),
      .take     (rsp_take),
      .head     (rsp_data),
      .cnt      (q_cnt)
   );

   // registers and window count
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= 64'd0;
         pattern_length_ff     <= 4'd0;
         replacement_bytes_ff  <= 64'd0;
         replacement_length_ff <= 4'd0;
         pend_ff               <= 3'd0;
      end else begin
         if (csr_we && csr_index == CSR_PATTERN_LENGTH) begin
            pend_ff <= 3'd0;
         end else if (req_take) begin
            pend_ff <= pend_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_BYTES: begin
                  pattern_bytes_ff <= csr_wdata;
               end
               CSR_PATTERN_LENGTH: begin
                  pattern_length_ff <= csr_wdata[3:0];
               end
               CSR_REPLACEMENT_BYTES: begin
                  replacement_bytes_ff <= csr_wdata;
               end
               CSR_REPLACEMENT_LENGTH: begin
                  replacement_length_ff <= csr_wdata[3:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   a_pend_below_plen: assert property (@(posedge clock) disable iff (reset)
      (plen != 4'd0) |-> (pend_ext < plen))
      else $error("window count not below pattern length");

   a_pend_zero_passthru: assert property (@(posedge clock) disable iff (reset)
      (plen == 4'd0) |-> (pend_ff == 3'd0))
      else $error("window holds bytes in pass-through mode");

   a_last_flushes: assert property (@(posedge clock) disable iff (reset)
      (req_take && last) |=> (pend_ff == 3'd0))
      else $error("window not empty after last byte");

   a_load_fits: assert property (@(posedge clock) disable iff (reset)
      q_load |-> (n <= 4'(QUEUE_DEPTH)) && (q_cnt == 4'd0 || rsp_take))
      else $error("result queue loaded while occupied");

endmodule

/* tb/ssr_rewrite_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssr_rewrite_checker
// Watches the csr, request and response ports of the substring replace block.
// Keeps its own copy of the registers and the pending window, predicts the
// rewritten bytes for every request transfer and compares each response
// transfer, field by field, with the oldest predicted result.
// ----------------------------------------------------------------------------
module ssr_rewrite_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  ssr_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  ssr_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [63:0]      csr_wdata,
   output int unsigned      mismatch_count,
   output int unsigned      results_checked,
   output int unsigned      matches_seen,
   output int unsigned      outstanding
);
   import ssr_pkg::*;

   localparam int unsigned MAX_RESULTS = 8;

   logic [63:0] pattern_reg;
   logic [3:0]  pattern_len_reg;
   logic [63:0] replace_reg;
   logic [3:0]  replace_len_reg;
   logic [7:0]  window_bytes [MAX_PATTERN];
   int unsigned window_fill;
   rsp_type     rewritten_q [$];

   task automatic rewrite_byte(input req_type item);
      rsp_type     batch [MAX_RESULTS];
      int unsigned plen, rlen, n, i;
      logic        hit;
      n = 0;
      plen = (pattern_len_reg > MAX_PATTERN) ? MAX_PATTERN : pattern_len_reg;
      rlen = (replace_len_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : replace_len_reg;
      if (plen == 0) begin
         batch[n] = '{item.text_byte, 1'b1, 1'b0};
         n++;
      end else begin
         if (window_fill < MAX_PATTERN) begin
            window_bytes[window_fill] = item.text_byte;
            window_fill++;
         end
         if (window_fill >= plen) begin
            hit = 1'b1;
            for (i = 0; i < plen; i++)
               if (window_bytes[i] != pattern_reg[8*i +: 8]) hit = 1'b0;
            if (hit) begin
               matches_seen++;
               for (i = 0; i < rlen; i++) begin
                  batch[n] = '{replace_reg[8*i +: 8], 1'b1, 1'b0};
                  n++;
               end
               window_fill = 0;
            end else begin
               batch[n] = '{window_bytes[0], 1'b1, 1'b0};
               n++;
               for (i = 1; i < window_fill; i++) window_bytes[i-1] = window_bytes[i];
               window_fill--;
            end
         end
      end
      if (item.text_last) begin
         for (i = 0; i < window_fill && n < MAX_RESULTS; i++) begin
            batch[n] = '{window_bytes[i], 1'b1, 1'b0};
            n++;
         end
         window_fill = 0;
         // bare end marker when nothing else is left to carry the last flag
         if (n == 0) begin
            batch[n] = '{8'h00, 1'b0, 1'b0};
            n++;
         end
         batch[n-1].out_last = 1'b1;
      end
      for (i = 0; i < n; i++) rewritten_q.push_back(batch[i]);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (rewritten_q.size() == 0) begin
         $display("%0t: unexpected result: byte %02h valid %b last %b",
                  $time, got.out_byte, got.out_valid, got.out_last);
         mismatch_count++;
         return;
      end
      want = rewritten_q.pop_front();
      results_checked++;
      if (got.out_byte !== want.out_byte) begin
         $display("%0t: out_byte expected %02h actual %02h",
                  $time, want.out_byte, got.out_byte);
         mismatch_count++;
      end
      if (got.out_valid !== want.out_valid) begin
         $display("%0t: out_valid expected %b actual %b",
                  $time, want.out_valid, got.out_valid);
         mismatch_count++;
      end
      if (got.out_last !== want.out_last) begin
         $display("%0t: out_last expected %b actual %b",
                  $time, want.out_last, got.out_last);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_reg     = '0;
         pattern_len_reg = '0;
         replace_reg     = '0;
         replace_len_reg = '0;
         window_fill     = 0;
         rewritten_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
         matches_seen    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_we) begin
            case (csr_index)
               CSR_PATTERN_BYTES:      pattern_reg = csr_wdata;
               CSR_PATTERN_LENGTH: begin
                  pattern_len_reg = csr_wdata[3:0];
                  window_fill     = 0;
               end
               CSR_REPLACEMENT_BYTES:  replace_reg = csr_wdata;
               CSR_REPLACEMENT_LENGTH: replace_len_reg = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) rewrite_byte(req_data);
      end
      outstanding = rewritten_q.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for stream_substring_replace_top. A directed opening
// covers pass-through, oversized lengths, deletion, a bare end marker and
// pattern changes in the middle of a text; random texts built around the
// current pattern follow, with random gaps on both channels and one long
// receiver hold-off. Checking is done by ssr_rewrite_checker.
// ----------------------------------------------------------------------------
module tb;
   import ssr_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 105;
   localparam int unsigned LONG_HOLD      = 80;
   localparam int unsigned SETTLE_CYCLES  = 4;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam logic [3:0]  MASK_ALL       = 4'hF;
   localparam logic [3:0]  MASK_PATTERN   =
      (4'b1 << CSR_PATTERN_BYTES) | (4'b1 << CSR_PATTERN_LENGTH);

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   int unsigned mismatch_count, results_checked, matches_seen, outstanding;
   int unsigned bytes_sent = 0;
   int unsigned texts_sent = 0;
   int unsigned settings_used = 0;
   int unsigned quiet_cycles = 0;
   logic        steady_sender = 1'b0;
   logic        hold_off_req = 1'b0;
   logic [7:0]  alphabet [4];
   logic [63:0] pattern_now = '0;
   int unsigned pattern_len_now = 0;

   stream_substring_replace_top dut (.*);

   ssr_rewrite_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 25);
   endfunction

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still due", $time, outstanding);
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver side
   initial begin
      int unsigned stall_len, run_len;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            stall_len = pick_gap();
            run_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
            if (stall_len > 0) begin
               rsp_stall <= 1'b1;
               repeat (stall_len) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{text_byte: b, text_last: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (last) texts_sent++;
   endtask

   task automatic send_text(input string s, input logic ends);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i], ends && (i == s.len() - 1));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_csr(input logic [1:0] idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [3:0] mask, input logic [63:0] pat,
                                 input logic [63:0] plen_word, input logic [63:0] rep,
                                 input logic [63:0] rlen_word);
      if (mask[CSR_PATTERN_BYTES])      put_csr(CSR_PATTERN_BYTES, pat);
      if (mask[CSR_PATTERN_LENGTH])     put_csr(CSR_PATTERN_LENGTH, plen_word);
      if (mask[CSR_REPLACEMENT_BYTES])  put_csr(CSR_REPLACEMENT_BYTES, rep);
      if (mask[CSR_REPLACEMENT_LENGTH]) put_csr(CSR_REPLACEMENT_LENGTH, rlen_word);
      csr_we <= 1'b0;
      if (mask[CSR_PATTERN_BYTES]) pattern_now = pat;
      if (mask[CSR_PATTERN_LENGTH])
         pattern_len_now = (plen_word[3:0] > MAX_PATTERN) ? MAX_PATTERN : plen_word[3:0];
      settings_used++;
   endtask

   task automatic pick_settings(input logic [3:0] mask);
      logic [63:0] pat, rep, plen_word, rlen_word;
      int unsigned roll, i;
      for (i = 0; i < 4; i++) alphabet[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < 8; i++) pat[8*i +: 8] = alphabet[$urandom_range(0, 3)];
      rep       = {$urandom, $urandom};
      plen_word = {$urandom, $urandom};
      rlen_word = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 10) plen_word[3:0] = 4'd0;
      else if (roll < 75) plen_word[3:0] = 4'($urandom_range(1, 4));
      else if (roll < 90) plen_word[3:0] = 4'($urandom_range(5, 8));
      else plen_word[3:0] = 4'($urandom_range(9, 15));
      roll = $urandom_range(0, 99);
      if (roll < 15) rlen_word[3:0] = 4'd0;
      else if (roll < 85) rlen_word[3:0] = 4'($urandom_range(1, 8));
      else rlen_word[3:0] = 4'($urandom_range(9, 15));
      write_settings(mask, pat, plen_word, rep, rlen_word);
   endtask

   task automatic send_random_text();
      logic [7:0]  text_q [$];
      int unsigned chunks, roll, part, k, i, cut;
      chunks = $urandom_range(1, 4);
      for (k = 0; k < chunks; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) part = pattern_len_now;
         else if (roll < 65 && pattern_len_now > 1) part = $urandom_range(1, pattern_len_now - 1);
         else part = 0;
         for (i = 0; i < part; i++) text_q.push_back(pattern_now[8*i +: 8]);
         if (part == 0) begin
            if (roll < 90) repeat ($urandom_range(1, 3)) text_q.push_back(alphabet[$urandom_range(0, 3)]);
            else text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      cut = ($urandom_range(0, 5) == 0 && text_q.size() > 1) ?
            $urandom_range(1, text_q.size() - 1) : 0;
      for (i = 0; i < text_q.size(); i++) begin
         // registers rewritten while bytes may still wait in the window
         if (cut != 0 && i == cut) begin
            drain();
            pick_settings(4'($urandom_range(1, 15)));
         end
         send_byte(text_q[i], i == text_q.size() - 1);
      end
   endtask

   initial begin
      int unsigned directed_bytes, phase;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_PATTERN_BYTES;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings pass text through
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h5A, 1'b1);
      drain();
      write_settings(MASK_ALL, 64'h6261, 64'd2, 64'h5A5958, 64'd3);
      send_text("xabaabab", 1'b1);
      drain();
      // oversized lengths act as eight
      write_settings(MASK_ALL, '1, 64'd15, '0, 64'd15);
      repeat (8) send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);
      drain();
      // deleted match on the last byte
      write_settings(MASK_ALL, 64'h71, 64'd1, '1, 64'd0);
      send_text("q", 1'b1);
      drain();
      write_settings(MASK_ALL, 64'h636261, 64'd3, 64'h2D, 64'd1);
      send_text("ab", 1'b0);
      drain();
      write_settings(MASK_PATTERN, 64'h6362, 64'd2, '0, '0);
      send_text("bc", 1'b1);
      directed_bytes = bytes_sent;

      phase = 0;
      while (bytes_sent < directed_bytes + RANDOM_ITEMS) begin
         drain();
         pick_settings(MASK_ALL);
         steady_sender = ($urandom_range(0, 3) == 0);
         if (phase == 1) begin
            steady_sender = 1'b1;
            hold_off_req  = 1'b1;
            while (hold_off_req) send_random_text();
         end else begin
            repeat ($urandom_range(1, 3)) send_random_text();
         end
         phase++;
      end
      steady_sender = 1'b0;
      drain();
      repeat (10) @(posedge clock);

      $display("covered %0d text bytes in %0d texts across %0d register settings",
               bytes_sent, texts_sent, settings_used);
      $display("checked %0d rewritten results, %0d pattern matches predicted",
               results_checked, matches_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
